// ===== src/ndrm_pkg.sv =====
`default_nettype none

package ndrm_pkg;

   // register map, in words
   typedef enum logic [0:0] {
      REG_TX_RING_LEN = 1'b0,
      REG_RX_RING_LEN = 1'b1
   } reg_index_type;

   // item kinds
   typedef enum logic [0:0] {
      KIND_SUBMIT = 1'b0,
      KIND_EVENT  = 1'b1
   } kind_type;

   // event reported for an interrupt beat
   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_TRANSMITTED = 3'd1,
      EV_RECEIVED    = 3'd2,
      EV_DROPPED     = 3'd3,
      EV_TX_ERROR    = 3'd4
   } event_type;

   // reason for a drop or a transmit error
   typedef enum logic [1:0] {
      RSN_RX_SMALL  = 2'd0,
      RSN_RING_FULL = 2'd1,
      RSN_BAD_DESC  = 2'd2,
      RSN_NET_ERR   = 2'd3
   } reason_type;

   // cause bit positions
   localparam int unsigned CAUSE_RX_DONE   = 0;
   localparam int unsigned CAUSE_TX_DONE   = 1;
   localparam int unsigned CAUSE_RX_SMALL  = 2;
   localparam int unsigned CAUSE_RING_FULL = 3;
   localparam int unsigned CAUSE_BAD_DESC  = 4;
   localparam int unsigned CAUSE_NET_ERR   = 5;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned CAUSE_W = 6;
   localparam int unsigned RLEN_W  = 5;
   localparam int unsigned RX_LEN_KEEP = 8;

endpackage

`default_nettype wire

// ===== src/ndrm_ram.sv =====
`default_nettype none

module ndrm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/nic_descriptor_ring_manager.sv =====
// A beat passes the input register, then the result register, which holds
// its result until the result side takes it.
// Throughput: one beat per cycle unless the result side stalls; after a ring
// length write the input stalls while the pointer successors are re-derived.
// Reset: pointers clear to zero, both ring lengths return to 2; the
// descriptor store is not cleared.
`default_nettype none

module nic_descriptor_ring_manager
   import ndrm_pkg::*;
#(
   parameter int unsigned RING_DEPTH = 16,
   parameter int unsigned MTU        = 2048
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // submit / interrupt beats
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_kind,
   input  wire logic [31:0]  req_buf_addr,
   input  wire logic [15:0]  req_buf_size,
   input  wire logic [15:0]  req_pkt_length,
   input  wire logic [5:0]   req_cause,
   // result beats
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_status,
   output logic [2:0]        rsp_event_res,
   output logic [1:0]        rsp_reason,
   output logic [31:0]       rsp_out_addr,
   output logic [15:0]       rsp_out_size,
   output logic [15:0]       rsp_out_length,
   output logic [5:0]        rsp_ack_mask,
   // register port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned PW    = $clog2(RING_DEPTH);
   localparam int unsigned LW    = PW + 1;
   localparam int unsigned CW    = (LW > RLEN_W) ? LW : RLEN_W;
   localparam int unsigned CNTW  = $clog2(LW + 1);
   localparam int unsigned DLEN_W = $clog2(MTU + 1);
   localparam int unsigned DESC_W = ADDR_W + SIZE_W + DLEN_W;
   localparam int unsigned NLANE = 3;
   localparam int unsigned LANE_HEAD = 0;
   localparam int unsigned LANE_TAIL = 1;
   localparam int unsigned LANE_RX   = 2;

   localparam logic [CW-1:0]    DEPTH_C = CW'(RING_DEPTH);
   localparam logic [CW-1:0]    MIN_C   = CW'(2);
   localparam logic [LEN_W-1:0] MTU_C   = LEN_W'(MTU);

   // registers
   logic [RLEN_W-1:0] tx_ring_len_ff, tx_ring_len_in;
   logic [RLEN_W-1:0] rx_ring_len_ff, rx_ring_len_in;

   logic [PW-1:0]   ptr_ff [NLANE];
   logic [PW-1:0]   ptr_in [NLANE];
   logic [PW-1:0]   nx_ff  [NLANE];
   logic [PW-1:0]   nx_in  [NLANE];

   logic [LW-1:0]   red_div_ff [NLANE];
   logic [LW-1:0]   red_div_in [NLANE];
   logic [LW-1:0]   red_rem_ff [NLANE];
   logic [LW-1:0]   red_rem_in [NLANE];
   logic [CNTW-1:0] red_cnt_ff, red_cnt_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_kind_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [SIZE_W-1:0]  s1_size_ff;
   logic [LEN_W-1:0]   s1_len_ff;
   logic [CAUSE_W-1:0] s1_cause_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [2:0]         rsp_event_ff, rsp_event_in;
   logic [1:0]         rsp_reason_ff, rsp_reason_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic [CAUSE_W-1:0] rsp_ack_ff, rsp_ack_in;

   logic               byp_hit_ff, byp_hit_in;
   logic [DESC_W-1:0]  byp_data_ff;

   // combinational
   logic              csr_wr;
   logic [CW-1:0]     tx_reg_w, rx_reg_w, txl_w, rxl_w;
   logic [LW-1:0]     lane_len [NLANE];
   logic              busy, advance, accept;
   logic              reject_basic, ring_full, submit_ok;
   logic              tx_evt, rx_evt;
   logic [PW-1:0]     rd_addr;
   logic [DESC_W-1:0] wr_data, ram_data, desc;
   logic [ADDR_W-1:0] desc_addr;
   logic [SIZE_W-1:0] desc_size;
   logic [DLEN_W-1:0] desc_len;
   logic [LW:0]       red_try [NLANE];
   logic [LW:0]       red_sub [NLANE];

   // register port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      tx_ring_len_in = tx_ring_len_ff;
      rx_ring_len_in = rx_ring_len_ff;
      if (csr_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_TX_RING_LEN: tx_ring_len_in = csr_pwdata[RLEN_W-1:0];
            REG_RX_RING_LEN: rx_ring_len_in = csr_pwdata[RLEN_W-1:0];
            default:         tx_ring_len_in = tx_ring_len_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_TX_RING_LEN: csr_prdata = 32'(tx_ring_len_ff);
         REG_RX_RING_LEN: csr_prdata = 32'(rx_ring_len_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ring lengths in use, saturated to 2 .. RING_DEPTH
   assign tx_reg_w = CW'(tx_ring_len_ff);
   assign rx_reg_w = CW'(rx_ring_len_ff);
   assign txl_w = (tx_reg_w < MIN_C) ? MIN_C : ((tx_reg_w > DEPTH_C) ? DEPTH_C : tx_reg_w);
   assign rxl_w = (rx_reg_w < MIN_C) ? MIN_C : ((rx_reg_w > DEPTH_C) ? DEPTH_C : rx_reg_w);
   assign lane_len[LANE_HEAD] = txl_w[LW-1:0];
   assign lane_len[LANE_TAIL] = txl_w[LW-1:0];
   assign lane_len[LANE_RX]   = rxl_w[LW-1:0];

   // handshake
   assign busy      = (red_cnt_ff != '0);
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   // descriptor seen at the tail, with write bypass
   assign ram_data  = byp_hit_ff ? byp_data_ff : desc;
   assign desc_addr = ram_data[DESC_W-1 -: ADDR_W];
   assign desc_size = ram_data[DLEN_W +: SIZE_W];
   assign desc_len  = ram_data[DLEN_W-1:0];

   // submit checks
   assign reject_basic = (s1_addr_ff == '0) || (s1_len_ff > MTU_C) ||
                         (s1_size_ff < s1_len_ff);
   assign ring_full = (nx_ff[LANE_HEAD] == ptr_ff[LANE_TAIL]);
   assign submit_ok = (s1_kind_ff == KIND_SUBMIT) && !reject_basic &&
                      (s1_len_ff != '0) && !ring_full;
   assign tx_evt = (s1_kind_ff == KIND_EVENT) &&
                   (s1_cause_ff[CAUSE_TX_DONE] ||
                    (!s1_cause_ff[CAUSE_RX_DONE] && !s1_cause_ff[CAUSE_RX_SMALL] &&
                     !s1_cause_ff[CAUSE_RING_FULL] &&
                     (s1_cause_ff[CAUSE_BAD_DESC] || s1_cause_ff[CAUSE_NET_ERR])));
   assign rx_evt = (s1_kind_ff == KIND_EVENT) && !s1_cause_ff[CAUSE_TX_DONE] &&
                   s1_cause_ff[CAUSE_RX_DONE];

   assign wr_data = {s1_addr_ff, s1_size_ff, s1_len_ff[DLEN_W-1:0]};
   assign rd_addr = ptr_in[LANE_TAIL];
   assign byp_hit_in = advance && submit_ok && (ptr_ff[LANE_HEAD] == rd_addr);

   // pointers, their wrap successors and the successor rebuild after a write
   always_comb begin
      for (int k = 0; k < NLANE; k++) begin
         ptr_in[k]     = ptr_ff[k];
         nx_in[k]      = nx_ff[k];
         red_div_in[k] = red_div_ff[k];
         red_rem_in[k] = red_rem_ff[k];
         red_try[k]    = {red_rem_ff[k], red_div_ff[k][LW-1]};
         red_sub[k]    = red_try[k] - {1'b0, lane_len[k]};
      end
      red_cnt_in = red_cnt_ff;

      if (csr_wr) begin
         // restart the successor rebuild: nx = (ptr + 1) mod len
         red_cnt_in = CNTW'(LW);
         for (int k = 0; k < NLANE; k++) begin
            red_div_in[k] = LW'({1'b0, ptr_ff[k]}) + LW'(1);
            red_rem_in[k] = '0;
         end
      end else if (busy) begin
         // one restoring step per cycle
         red_cnt_in = red_cnt_ff - CNTW'(1);
         for (int k = 0; k < NLANE; k++) begin
            red_div_in[k] = {red_div_ff[k][LW-2:0], 1'b0};
            if (red_try[k] >= {1'b0, lane_len[k]}) begin
               red_rem_in[k] = red_sub[k][LW-1:0];
            end else begin
               red_rem_in[k] = red_try[k][LW-1:0];
            end
            if (red_cnt_ff == CNTW'(1)) begin
               nx_in[k] = red_rem_in[k][PW-1:0];
            end
         end
      end else if (advance) begin
         if (submit_ok) begin
            ptr_in[LANE_HEAD] = nx_ff[LANE_HEAD];
            nx_in[LANE_HEAD]  = (LW'({1'b0, nx_ff[LANE_HEAD]}) + LW'(1) == lane_len[LANE_HEAD])
                                ? '0 : nx_ff[LANE_HEAD] + PW'(1);
         end
         if (tx_evt) begin
            ptr_in[LANE_TAIL] = nx_ff[LANE_TAIL];
            nx_in[LANE_TAIL]  = (LW'({1'b0, nx_ff[LANE_TAIL]}) + LW'(1) == lane_len[LANE_TAIL])
                                ? '0 : nx_ff[LANE_TAIL] + PW'(1);
         end
         if (rx_evt) begin
            ptr_in[LANE_RX] = nx_ff[LANE_RX];
            nx_in[LANE_RX]  = (LW'({1'b0, nx_ff[LANE_RX]}) + LW'(1) == lane_len[LANE_RX])
                              ? '0 : nx_ff[LANE_RX] + PW'(1);
         end
      end
   end

   // result of the beat in the input register
   always_comb begin
      rsp_status_in = 1'b0;
      rsp_event_in  = EV_NONE;
      rsp_reason_in = RSN_RX_SMALL;
      rsp_addr_in   = '0;
      rsp_size_in   = '0;
      rsp_length_in = '0;
      rsp_ack_in    = '0;
      if (s1_kind_ff == KIND_SUBMIT) begin
         rsp_status_in = reject_basic || ((s1_len_ff != '0) && ring_full);
      end else if (s1_cause_ff[CAUSE_TX_DONE]) begin
         rsp_event_in = EV_TRANSMITTED;
         rsp_ack_in[CAUSE_TX_DONE] = 1'b1;
         rsp_addr_in  = desc_addr;
         rsp_size_in  = desc_size;
      end else if (s1_cause_ff[CAUSE_RX_DONE]) begin
         rsp_event_in  = EV_RECEIVED;
         rsp_ack_in[CAUSE_RX_DONE] = 1'b1;
         rsp_addr_in   = s1_addr_ff;
         rsp_size_in   = s1_size_ff;
         rsp_length_in = LEN_W'(s1_len_ff[RX_LEN_KEEP-1:0]);
      end else if (s1_cause_ff[CAUSE_RX_SMALL]) begin
         rsp_event_in  = EV_DROPPED;
         rsp_reason_in = RSN_RX_SMALL;
         rsp_ack_in[CAUSE_RX_SMALL] = 1'b1;
      end else if (s1_cause_ff[CAUSE_RING_FULL]) begin
         rsp_event_in  = EV_DROPPED;
         rsp_reason_in = RSN_RING_FULL;
         rsp_ack_in[CAUSE_RING_FULL] = 1'b1;
      end else if (s1_cause_ff[CAUSE_BAD_DESC] || s1_cause_ff[CAUSE_NET_ERR]) begin
         rsp_event_in  = EV_TX_ERROR;
         if (s1_cause_ff[CAUSE_BAD_DESC]) begin
            rsp_reason_in = RSN_BAD_DESC;
            rsp_ack_in[CAUSE_BAD_DESC] = 1'b1;
         end else begin
            rsp_reason_in = RSN_NET_ERR;
            rsp_ack_in[CAUSE_NET_ERR] = 1'b1;
         end
         rsp_addr_in   = desc_addr;
         rsp_size_in   = desc_size;
         rsp_length_in = LEN_W'(desc_len);
      end
   end

   // stage valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ring_len_ff <= RLEN_W'(2);
         rx_ring_len_ff <= RLEN_W'(2);
         red_cnt_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byp_hit_ff     <= 1'b0;
         for (int k = 0; k < NLANE; k++) begin
            ptr_ff[k] <= '0;
            nx_ff[k]  <= PW'(1);
         end
      end else begin
         tx_ring_len_ff <= tx_ring_len_in;
         rx_ring_len_ff <= rx_ring_len_in;
         red_cnt_ff     <= red_cnt_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         byp_hit_ff     <= byp_hit_in;
         for (int k = 0; k < NLANE; k++) begin
            ptr_ff[k] <= ptr_in[k];
            nx_ff[k]  <= nx_in[k];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < NLANE; k++) begin
         red_div_ff[k] <= red_div_in[k];
         red_rem_ff[k] <= red_rem_in[k];
      end
      byp_data_ff <= wr_data;
      if (accept) begin
         s1_kind_ff  <= req_kind;
         s1_addr_ff  <= req_buf_addr;
         s1_size_ff  <= req_buf_size;
         s1_len_ff   <= req_pkt_length;
         s1_cause_ff <= req_cause;
      end
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_event_ff  <= rsp_event_in;
         rsp_reason_ff <= rsp_reason_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_length_ff <= rsp_length_in;
         rsp_ack_ff    <= rsp_ack_in;
      end
   end

   // transmit descriptor store
   ndrm_ram #(
      .WIDTH (DESC_W),
      .DEPTH (RING_DEPTH)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (advance && submit_ok),
      .wr_addr (ptr_ff[LANE_HEAD]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (desc)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_reason     = rsp_reason_ff;
   assign rsp_out_addr   = rsp_addr_ff;
   assign rsp_out_size   = rsp_size_ff;
   assign rsp_out_length = rsp_length_ff;
   assign rsp_ack_mask   = rsp_ack_ff;

endmodule

`default_nettype wire

// ===== tb/tb_nic_descriptor_ring_manager.sv =====
`timescale 1ns / 100ps

module tb_nic_descriptor_ring_manager;
   import ndrm_pkg::*;

   localparam int unsigned RING_SLOTS   = 16;
   localparam int unsigned MTU_BYTES    = 2048;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_BEATS  = 160;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned REPORT_LIMIT = 10;

   // one request beat and one result beat
   typedef struct {
      kind_type    kind;
      logic [31:0] buf_addr;
      logic [15:0] buf_size;
      logic [15:0] pkt_length;
      logic [5:0]  cause;
   } req_beat_type;

   typedef struct {
      logic        status;
      event_type   event_res;
      reason_type  reason;
      logic [31:0] out_addr;
      logic [15:0] out_size;
      logic [15:0] out_length;
      logic [5:0]  ack_mask;
   } rsp_beat_type;

   // shadow of the descriptor ring and its pointers, plus the results still owed
   class ring_tracker_type;
      int unsigned tx_len_reg;
      int unsigned rx_len_reg;
      int unsigned tx_head;
      int unsigned tx_tail;
      int unsigned rx_tail;
      logic [31:0] addr_store [RING_SLOTS];
      logic [15:0] size_store [RING_SLOTS];
      logic [15:0] len_store [RING_SLOTS];
      bit          slot_written [RING_SLOTS];
      rsp_beat_type pending_results [$];
      int unsigned mismatches;

      function new();
         tx_len_reg  = 2;
         rx_len_reg  = 2;
         tx_head     = 0;
         tx_tail     = 0;
         rx_tail     = 0;
         mismatches  = 0;
         foreach (slot_written[i]) slot_written[i] = 1'b0;
      endfunction

      function void write_reg(reg_index_type idx, logic [4:0] value);
         if (idx == REG_TX_RING_LEN) begin
            tx_len_reg = value;
         end else begin
            rx_len_reg = value;
         end
      endfunction

      // out-of-range lengths saturate when used
      function int unsigned clamp_len(int unsigned raw);
         if (raw < 2) return 2;
         if (raw > RING_SLOTS) return RING_SLOTS;
         return raw;
      endfunction

      // work out the result of an accepted beat and update the shadow state
      function void accept_beat(req_beat_type beat);
         rsp_beat_type want;
         int unsigned txl;
         int unsigned rxl;
         int unsigned next_head;
         int unsigned slot;
         txl             = clamp_len(tx_len_reg);
         rxl             = clamp_len(rx_len_reg);
         slot            = tx_tail % RING_SLOTS;
         want.status     = 1'b0;
         want.event_res  = EV_NONE;
         want.reason     = RSN_RX_SMALL;
         want.out_addr   = '0;
         want.out_size   = '0;
         want.out_length = '0;
         want.ack_mask   = '0;
         if (beat.kind == KIND_SUBMIT) begin
            // sanity checks first; a zero length skips the full check
            if (beat.buf_addr == 0 || beat.pkt_length > MTU_BYTES ||
                beat.buf_size < beat.pkt_length) begin
               want.status = 1'b1;
            end else if (beat.pkt_length != 0) begin
               next_head = (tx_head + 1) % txl;
               if (next_head == tx_tail) begin
                  want.status = 1'b1;
               end else begin
                  addr_store[tx_head % RING_SLOTS]   = beat.buf_addr;
                  size_store[tx_head % RING_SLOTS]   = beat.buf_size;
                  len_store[tx_head % RING_SLOTS]    = beat.pkt_length;
                  slot_written[tx_head % RING_SLOTS] = 1'b1;
                  tx_head = next_head;
               end
            end
         end else if (beat.cause[CAUSE_TX_DONE]) begin
            want.event_res               = EV_TRANSMITTED;
            want.ack_mask[CAUSE_TX_DONE] = 1'b1;
            want.out_addr                = addr_store[slot];
            want.out_size                = size_store[slot];
            tx_tail                      = (tx_tail + 1) % txl;
         end else if (beat.cause[CAUSE_RX_DONE]) begin
            want.event_res               = EV_RECEIVED;
            want.ack_mask[CAUSE_RX_DONE] = 1'b1;
            want.out_addr                = beat.buf_addr;
            want.out_size                = beat.buf_size;
            want.out_length              = {8'h00, beat.pkt_length[7:0]};
            rx_tail                      = (rx_tail + 1) % rxl;
         end else if (beat.cause[CAUSE_RX_SMALL]) begin
            want.event_res                = EV_DROPPED;
            want.reason                   = RSN_RX_SMALL;
            want.ack_mask[CAUSE_RX_SMALL] = 1'b1;
         end else if (beat.cause[CAUSE_RING_FULL]) begin
            want.event_res                 = EV_DROPPED;
            want.reason                    = RSN_RING_FULL;
            want.ack_mask[CAUSE_RING_FULL] = 1'b1;
         end else if (beat.cause[CAUSE_BAD_DESC] || beat.cause[CAUSE_NET_ERR]) begin
            want.event_res = EV_TX_ERROR;
            if (beat.cause[CAUSE_BAD_DESC]) begin
               want.reason                   = RSN_BAD_DESC;
               want.ack_mask[CAUSE_BAD_DESC] = 1'b1;
            end else begin
               want.reason                  = RSN_NET_ERR;
               want.ack_mask[CAUSE_NET_ERR] = 1'b1;
            end
            want.out_addr   = addr_store[slot];
            want.out_size   = size_store[slot];
            want.out_length = len_store[slot];
            tx_tail         = (tx_tail + 1) % txl;
         end
         pending_results.push_back(want);
      endfunction

      // compare a result beat against the oldest one owed
      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat: st=%0d ev=%0d rsn=%0d addr=%h size=%h len=%h ack=%h",
                        got.status, got.event_res, got.reason, got.out_addr,
                        got.out_size, got.out_length, got.ack_mask);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.event_res !== want.event_res ||
             got.reason !== want.reason || got.out_addr !== want.out_addr ||
             got.out_size !== want.out_size || got.out_length !== want.out_length ||
             got.ack_mask !== want.ack_mask) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result mismatch at %0t", $realtime);
               $display("  expected st=%0d ev=%0d rsn=%0d addr=%h size=%h len=%h ack=%h",
                        want.status, want.event_res, want.reason, want.out_addr,
                        want.out_size, want.out_length, want.ack_mask);
               $display("  actual   st=%0d ev=%0d rsn=%0d addr=%h size=%h len=%h ack=%h",
                        got.status, got.event_res, got.reason, got.out_addr,
                        got.out_size, got.out_length, got.ack_mask);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [31:0] req_buf_addr;
   logic [15:0] req_buf_size;
   logic [15:0] req_pkt_length;
   logic [5:0]  req_cause;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic [2:0]  rsp_event_res;
   logic [1:0]  rsp_reason;
   logic [31:0] rsp_out_addr;
   logic [15:0] rsp_out_size;
   logic [15:0] rsp_out_length;
   logic [5:0]  rsp_ack_mask;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ring_tracker_type tracker;
   int unsigned snd_idle_pct;
   int unsigned rcv_idle_pct;
   int unsigned cycle_count;

   // ring length plan per phase, extremes and out-of-range values among them
   int unsigned tx_plan [PHASES] = '{16, 0, 5, 1, 31, 9, 16, 2};
   int unsigned rx_plan [PHASES] = '{16, 31, 3, 17, 0, 12, 2, 7};

   nic_descriptor_ring_manager #(
      .RING_DEPTH(RING_SLOTS),
      .MTU       (MTU_BYTES)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_buf_addr  (req_buf_addr),
      .req_buf_size  (req_buf_size),
      .req_pkt_length(req_pkt_length),
      .req_cause     (req_cause),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_event_res (rsp_event_res),
      .rsp_reason    (rsp_reason),
      .rsp_out_addr  (rsp_out_addr),
      .rsp_out_size  (rsp_out_size),
      .rsp_out_length(rsp_out_length),
      .rsp_ack_mask  (rsp_ack_mask),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // result beats
   always @(posedge clock) begin
      rsp_beat_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status     = rsp_status;
         got.event_res  = event_type'(rsp_event_res);
         got.reason     = reason_type'(rsp_reason);
         got.out_addr   = rsp_out_addr;
         got.out_size   = rsp_out_size;
         got.out_length = rsp_out_length;
         got.ack_mask   = rsp_ack_mask;
         tracker.check_result(got);
      end
   end

   function automatic req_beat_type make_beat(kind_type kind, logic [31:0] addr,
                                              logic [15:0] size, logic [15:0] len,
                                              logic [5:0] cause);
      req_beat_type beat;
      beat.kind       = kind;
      beat.buf_addr   = addr;
      beat.buf_size   = size;
      beat.pkt_length = len;
      beat.cause      = cause;
      return beat;
   endfunction

   // drive one request beat, called at a falling edge, returns at a falling edge
   task automatic drive_beat(input req_beat_type beat);
      // never report a transmit slot that was not written since reset
      if (beat.kind == KIND_EVENT && !tracker.slot_written[tracker.tx_tail % RING_SLOTS]) begin
         beat.cause[CAUSE_TX_DONE]  = 1'b0;
         beat.cause[CAUSE_BAD_DESC] = 1'b0;
         beat.cause[CAUSE_NET_ERR]  = 1'b0;
      end
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= beat.kind;
      req_buf_addr   <= beat.buf_addr;
      req_buf_size   <= beat.buf_size;
      req_pkt_length <= beat.pkt_length;
      req_cause      <= beat.cause;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.accept_beat(beat);
      @(negedge clock);
   endtask

   // register write: setup, access, then idle; called at a falling edge
   task automatic write_ring_len(input reg_index_type idx, input logic [4:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * int'(idx));
      csr_pwdata  <= {27'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every owed result has come back, then sit at a falling edge
   task automatic drain_results();
      while (tracker.pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      req_beat_type beat;
      int unsigned pick;
      int unsigned len;
      tracker        = new();
      snd_idle_pct   = 8;
      rcv_idle_pct   = 79;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_SUBMIT;
      req_buf_addr   = '0;
      req_buf_size   = '0;
      req_pkt_length = '0;
      req_cause      = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed beats at the reset ring lengths (one usable descriptor)
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h00));
      drive_beat(make_beat(KIND_EVENT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'h01));
      drive_beat(make_beat(KIND_EVENT, 32'h5A5A_5A5A, 16'h1234, 16'h0FF0, 6'h3C));
      drive_beat(make_beat(KIND_EVENT, 32'hA5A5_A5A5, 16'hEDCB, 16'hF00F, 6'h38));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0, 16'hFFFF, 16'd64, 6'h3F));
      drive_beat(make_beat(KIND_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 16'(MTU_BYTES + 1), 6'h00));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0000_1000, 16'd99, 16'd100, 6'h15));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0000_0001, 16'h0, 16'h0, 6'h00));
      drive_beat(make_beat(KIND_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 16'(MTU_BYTES), 6'h00));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0000_0004, 16'd5, 16'd5, 6'h2A));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0000_0008, 16'd7, 16'd0, 6'h00));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h3F));
      drive_beat(make_beat(KIND_SUBMIT, 32'h1234_5678, 16'd1, 16'd1, 6'h00));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h30));
      drive_beat(make_beat(KIND_SUBMIT, 32'h8000_0000, 16'h8000, 16'h07FF, 6'h00));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h20));
      drive_beat(make_beat(KIND_EVENT, 32'h0F0F_0F0F, 16'h00FF, 16'h01AB, 6'h3D));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h02));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h10));
      drive_beat(make_beat(KIND_SUBMIT, 32'h0000_0010, 16'hFFFF, 16'hFFFF, 6'h00));
      drive_beat(make_beat(KIND_EVENT, 32'h0, 16'h0, 16'h0, 6'h04));

      // random phases, each at its own pair of ring lengths
      for (int phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         drain_results();
         write_ring_len(REG_TX_RING_LEN, 5'(tx_plan[phase]));
         write_ring_len(REG_RX_RING_LEN, 5'(rx_plan[phase]));
         if (phase < 3) begin
            snd_idle_pct = 8;
            rcv_idle_pct = 79;
         end else if (phase < 6) begin
            snd_idle_pct = 79;
            rcv_idle_pct = 8;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            beat.kind       = ($urandom_range(0, 99) < 50) ? KIND_SUBMIT : KIND_EVENT;
            beat.buf_addr   = $urandom;
            beat.buf_size   = 16'($urandom);
            beat.pkt_length = 16'($urandom);
            beat.cause      = 6'($urandom);
            pick            = $urandom_range(0, 99);
            if (beat.kind == KIND_SUBMIT) begin
               if (pick < 87 && beat.buf_addr == 0) beat.buf_addr = 32'h1;
               if (pick < 70) begin
                  // well-formed descriptor, mostly short frames
                  len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, MTU_BYTES)
                                                    : $urandom_range(1, 64);
                  beat.pkt_length = 16'(len);
                  beat.buf_size   = 16'($urandom_range(len, 16'hFFFF));
               end else if (pick < 80) begin
                  beat.pkt_length = '0;
               end else if (pick < 87) begin
                  beat.buf_addr = '0;
               end else if (pick < 94) begin
                  beat.pkt_length = 16'($urandom_range(MTU_BYTES + 1, 16'hFFFF));
               end else begin
                  len = $urandom_range(1, MTU_BYTES);
                  beat.pkt_length = 16'(len);
                  beat.buf_size   = 16'($urandom_range(0, len - 1));
               end
            end else begin
               if (pick < 55) begin
                  beat.cause = 6'(1 << $urandom_range(0, 5));
               end else if (pick < 65) begin
                  beat.cause = '0;
               end
            end
            drive_beat(beat);
         end
      end

      // let the last results come home
      req_valid <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);
      tracker.mismatches += tracker.pending_results.size();
      if (tracker.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== nic_descriptor_ring_manager.f =====
src/ndrm_pkg.sv
src/ndrm_ram.sv
src/nic_descriptor_ring_manager.sv
tb/tb_nic_descriptor_ring_manager.sv
